// File: rtl/core/page_bitmap_allocator_macros.svh
// Assertion macros used by the allocator controller.
// Each macro checks one implication on the rising clock edge,
// with the check held off while the asynchronous reset is active.
`ifndef PAGE_BITMAP_ALLOCATOR_MACROS_SVH
`define PAGE_BITMAP_ALLOCATOR_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication.
`define PBA_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
		else $error("allocator check failed");

// Next-cycle implication.
`define PBA_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
		else $error("allocator check failed");

`else

`define PBA_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons)
`define PBA_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons)

`endif

`endif

// File: rtl/core/pba_pkg.sv
package pba_pkg;

	// Map geometry
	localparam int MAX_PAGES     = 4096;
	localparam int MAP_WORD_BITS = 64;
	localparam int MAP_WORDS     = (MAX_PAGES + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
	localparam int WORD_IDX_W    = $clog2(MAP_WORDS);
	localparam int BIT_IDX_W     = $clog2(MAP_WORD_BITS);
	localparam int PAGE_IDX_W    = $clog2(MAX_PAGES);

	// Field widths
	localparam int ACTION_W = 2;
	localparam int PAGE_W   = 40;
	localparam int COUNT_W  = 13;

	// Action codes
	localparam logic [ACTION_W-1:0] ACT_ALLOC   = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_FREE    = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_RESERVE = 2'd2;

	// Configuration register indexes
	localparam logic REG_BASE  = 1'b0;
	localparam logic REG_PAGES = 1'b1;

	// Register reset values
	localparam logic [PAGE_W-1:0]  BASE_RESET  = '0;
	localparam logic [COUNT_W-1:0] PAGES_RESET = COUNT_W'(MAX_PAGES);

	typedef struct packed {
		logic [ACTION_W-1:0] action;
		logic [PAGE_W-1:0]   page_number;
		logic [COUNT_W-1:0]  page_count;
	} pba_item_t;

	typedef struct packed {
		logic              status;
		logic [PAGE_W-1:0] start_page;
	} pba_result_t;

	// How an item finishes
	typedef enum logic [1:0] {
		FIN_FAIL,
		FIN_OK,
		FIN_ALLOC
	} pba_fin_t;

	// Controller to datapath
	typedef struct packed {
		logic     load;
		logic     init;
		logic     scan;
		logic     mark_rd;
		logic     finish;
		pba_fin_t fin;
	} pba_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic is_alloc;
		logic is_put;
		logic count_zero;
		logic alloc_ok;
		logic put_ok;
		logic found;
		logic scan_fail;
		logic mark_at_last;
	} pba_stat_t;

endpackage

// File: rtl/core/pba_ram.sv
module pba_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: rtl/core/pba_datapath.sv
module pba_datapath import pba_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  pba_cmd_t          cmd,
	output pba_stat_t         stat,
	input  pba_item_t         item,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [PAGE_W-1:0] cfg_data,
	output pba_result_t       result
);

	// Lowest clear bit, or the word width when all bits are set
	function automatic logic [BIT_IDX_W:0] trail_ones(input logic [MAP_WORD_BITS-1:0] v);
		logic [BIT_IDX_W:0] n;
		n = (BIT_IDX_W+1)'(MAP_WORD_BITS);
		for (int i = MAP_WORD_BITS - 1; i >= 0; i--) begin
			if (!v[i]) begin
				n = (BIT_IDX_W+1)'(i);
			end
		end
		return n;
	endfunction

	// Run of set bits at the top of the word
	function automatic logic [BIT_IDX_W:0] lead_ones(input logic [MAP_WORD_BITS-1:0] v);
		logic [BIT_IDX_W:0] n;
		n = (BIT_IDX_W+1)'(MAP_WORD_BITS);
		for (int i = 0; i < MAP_WORD_BITS; i++) begin
			if (!v[i]) begin
				n = (BIT_IDX_W+1)'(MAP_WORD_BITS - 1 - i);
			end
		end
		return n;
	endfunction

	// Index of the lowest set bit
	function automatic logic [BIT_IDX_W-1:0] low_set(input logic [MAP_WORD_BITS-1:0] v);
		logic [BIT_IDX_W-1:0] p;
		p = '0;
		for (int i = MAP_WORD_BITS - 1; i >= 0; i--) begin
			if (v[i]) begin
				p = BIT_IDX_W'(i);
			end
		end
		return p;
	endfunction

	// Item and configuration
	logic [ACTION_W-1:0] action_q;
	logic [PAGE_W-1:0]   page_q;
	logic [COUNT_W-1:0]  count_q;
	logic [PAGE_W-1:0]   base_q;
	logic [COUNT_W-1:0]  pages_q;

	// Walk state
	logic [WORD_IDX_W-1:0] ptr_q;
	logic                  pend_s1;
	logic                  mark_s1;
	logic [WORD_IDX_W-1:0] addr_s1;
	logic                  vbit_s1;
	logic [MAP_WORDS-1:0]  valid_q;
	logic [COUNT_W-1:0]    run_q;
	logic [COUNT_W-1:0]    run_start_q;
	logic [PAGE_IDX_W-1:0] first_q;
	logic [PAGE_IDX_W-1:0] last_q;
	pba_result_t           res_q;

	logic [COUNT_W-1:0]         size;
	logic [COUNT_W:0]           words_sum;
	logic [COUNT_W-BIT_IDX_W:0] nwords;
	logic [WORD_IDX_W-1:0]      last_word;
	logic [PAGE_W-1:0]          off;
	logic [COUNT_W:0]           span;
	logic [PAGE_IDX_W-1:0]      put_first;
	logic [PAGE_IDX_W-1:0]      put_last;

	logic [MAP_WORD_BITS-1:0]   rdata;
	logic [MAP_WORD_BITS-1:0]   x_raw;
	logic [MAP_WORD_BITS-1:0]   x;
	logic                       is_last;
	logic [BIT_IDX_W-1:0]       tail_bits;
	logic [BIT_IDX_W:0]         tail_sh;
	logic [MAP_WORD_BITS-1:0]   tail_mask;
	logic [BIT_IDX_W:0]         t0;
	logic [BIT_IDX_W:0]         lead;
	logic [COUNT_W-1:0]         need;
	logic                       cont_hit;
	logic                       int_ok;
	logic                       int_hit;
	logic [BIT_IDX_W-1:0]       int_pos;
	logic [MAP_WORD_BITS-1:0]   pw [BIT_IDX_W+1];
	logic [2*MAP_WORD_BITS-1:0] win;
	logic                       found_any;
	logic [COUNT_W-1:0]         found_start;
	logic [COUNT_W-1:0]         word_base;
	logic [COUNT_W-1:0]         run_next;
	logic [COUNT_W-1:0]         run_start_next;
	logic                       eval;
	logic                       rd_en;

	logic                     wr;
	logic [BIT_IDX_W-1:0]     lo;
	logic [BIT_IDX_W-1:0]     hi;
	logic [MAP_WORD_BITS-1:0] put_mask;
	logic [MAP_WORD_BITS-1:0] wdata;
	logic                     freed;

	// Region size and word count
	assign size      = (pages_q > COUNT_W'(MAX_PAGES)) ? COUNT_W'(MAX_PAGES) : pages_q;
	assign words_sum = {1'b0, size} + (COUNT_W+1)'(MAP_WORD_BITS - 1);
	assign nwords    = words_sum[COUNT_W:BIT_IDX_W];
	assign last_word = WORD_IDX_W'(nwords - 1'b1);

	// Range check for free and reserve
	assign off       = page_q - base_q;
	assign span      = {1'b0, off[COUNT_W-1:0]} + {1'b0, count_q};
	assign put_first = off[PAGE_IDX_W-1:0];
	assign put_last  = PAGE_IDX_W'(off[COUNT_W-1:0] + count_q - 1'b1);

	assign stat.is_alloc   = (action_q == ACT_ALLOC);
	assign stat.is_put     = (action_q == ACT_FREE) || (action_q == ACT_RESERVE);
	assign stat.count_zero = (count_q == '0);
	assign stat.alloc_ok   = (count_q != '0) && (count_q <= size);
	assign stat.put_ok     = (page_q >= base_q) && (off[PAGE_W-1:COUNT_W] == '0)
		&& (span <= {1'b0, size});

	// Map word as read; unwritten words read as all free
	assign x_raw     = vbit_s1 ? rdata : '1;
	assign is_last   = (addr_s1 == last_word);
	assign tail_bits = size[BIT_IDX_W-1:0];
	assign tail_sh   = (BIT_IDX_W+1)'(MAP_WORD_BITS) - {1'b0, tail_bits};
	assign tail_mask = (is_last && (tail_bits != '0)) ? ({MAP_WORD_BITS{1'b1}} >> tail_sh) : '1;
	assign x         = x_raw & tail_mask;

	// Run carried in from lower words
	assign t0       = trail_ones(x);
	assign need     = count_q - run_q;
	assign cont_hit = (need <= COUNT_W'(t0));

	// Windows of count set bits wholly inside the word
	always_comb begin
		pw[0] = x;
		for (int j = 1; j <= BIT_IDX_W; j++) begin
			pw[j] = pw[j-1] & (pw[j-1] >> (1 << (j - 1)));
		end
		win = {{(MAP_WORD_BITS-1){1'b0}}, {(MAP_WORD_BITS+1){1'b1}}};
		for (int j = 0; j <= BIT_IDX_W; j++) begin
			if (count_q[j]) begin
				win = {{MAP_WORD_BITS{1'b0}}, pw[j] & win[(1 << j) +: MAP_WORD_BITS]};
			end
		end
	end

	assign int_ok  = (count_q[COUNT_W-1:BIT_IDX_W+1] == '0);
	assign int_hit = int_ok && (win[MAP_WORD_BITS-1:0] != '0);
	assign int_pos = low_set(win[MAP_WORD_BITS-1:0]);

	assign found_any   = cont_hit || int_hit;
	assign found_start = cont_hit ? run_start_q : COUNT_W'({addr_s1, int_pos});

	// Run carried out to the next word
	assign lead           = lead_ones(x);
	assign word_base      = COUNT_W'({addr_s1, {BIT_IDX_W{1'b0}}});
	assign run_next       = (&x) ? run_q + COUNT_W'(MAP_WORD_BITS) : COUNT_W'(lead);
	assign run_start_next = (&x) ? run_start_q
		: word_base + COUNT_W'(MAP_WORD_BITS) - COUNT_W'(lead);

	assign eval           = cmd.scan && pend_s1 && !mark_s1;
	assign stat.found     = eval && found_any;
	assign stat.scan_fail = eval && !found_any && is_last;
	assign rd_en          = cmd.scan || cmd.mark_rd;

	assign stat.mark_at_last = (ptr_q == last_q[PAGE_IDX_W-1:BIT_IDX_W]);

	// Read-modify-write of one word of the range
	assign freed    = (action_q == ACT_FREE);
	assign wr       = pend_s1 && mark_s1;
	assign lo       = (addr_s1 == first_q[PAGE_IDX_W-1:BIT_IDX_W])
		? first_q[BIT_IDX_W-1:0] : '0;
	assign hi       = (addr_s1 == last_q[PAGE_IDX_W-1:BIT_IDX_W])
		? last_q[BIT_IDX_W-1:0] : '1;
	assign put_mask = ({MAP_WORD_BITS{1'b1}} << lo)
		& ({MAP_WORD_BITS{1'b1}} >> (BIT_IDX_W'(MAP_WORD_BITS - 1) - hi));
	assign wdata    = freed ? (x_raw | put_mask) : (x_raw & ~put_mask);

	pba_ram #(
		.WIDTH(MAP_WORD_BITS),
		.DEPTH(MAP_WORDS)
	) u_map (
		.clk  (clk),
		.we   (wr),
		.waddr(addr_s1),
		.wdata(wdata),
		.re   (rd_en),
		.raddr(ptr_q),
		.rdata(rdata)
	);

	// Control state, configuration and walk pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q      <= BASE_RESET;
			pages_q     <= PAGES_RESET;
			ptr_q       <= '0;
			pend_s1     <= 1'b0;
			mark_s1     <= 1'b0;
			valid_q     <= '0;
			run_q       <= '0;
			run_start_q <= '0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_BASE) begin
					base_q <= cfg_data;
				end else begin
					pages_q <= cfg_data[COUNT_W-1:0];
				end
			end
			pend_s1 <= rd_en;
			mark_s1 <= cmd.mark_rd;
			if (wr) begin
				valid_q[addr_s1] <= 1'b1;
			end
			if (cmd.init) begin
				ptr_q       <= stat.is_alloc ? '0 : put_first[PAGE_IDX_W-1:BIT_IDX_W];
				run_q       <= '0;
				run_start_q <= '0;
			end else if (stat.found) begin
				ptr_q <= found_start[PAGE_IDX_W-1:BIT_IDX_W];
			end else begin
				if (rd_en) begin
					ptr_q <= ptr_q + 1'b1;
				end
				if (eval) begin
					run_q       <= run_next;
					run_start_q <= run_start_next;
				end
			end
		end
	end

	// Item, read tags, range bounds and result
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			action_q <= item.action;
			page_q   <= item.page_number;
			count_q  <= item.page_count;
		end
		if (rd_en) begin
			addr_s1 <= ptr_q;
			vbit_s1 <= valid_q[ptr_q];
		end
		if (cmd.init) begin
			first_q <= put_first;
			last_q  <= put_last;
		end else if (stat.found) begin
			first_q <= found_start[PAGE_IDX_W-1:0];
			last_q  <= PAGE_IDX_W'(found_start + count_q - 1'b1);
		end
		if (cmd.finish) begin
			case (cmd.fin)
				FIN_OK: begin
					res_q.status     <= 1'b0;
					res_q.start_page <= '0;
				end
				FIN_ALLOC: begin
					res_q.status     <= 1'b0;
					res_q.start_page <= base_q + PAGE_W'(first_q);
				end
				default: begin
					res_q.status     <= 1'b1;
					res_q.start_page <= '0;
				end
			endcase
		end
	end

	assign result = res_q;

endmodule

// File: rtl/core/pba_ctrl.sv
`include "page_bitmap_allocator_macros.svh"

module pba_ctrl import pba_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	output logic      done,
	input  pba_stat_t stat,
	output pba_cmd_t  cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_SCAN,
		ST_MARK,
		ST_MARK_END
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   done_q;

	// Sequence one item: check, scan, mark, report
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.fin = FIN_FAIL;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (stat.is_alloc && stat.alloc_ok) begin
					cmd.init = 1'b1;
					state_d  = ST_SCAN;
				end else if (stat.is_put && stat.put_ok && !stat.count_zero) begin
					cmd.init = 1'b1;
					state_d  = ST_MARK;
				end else begin
					cmd.finish = 1'b1;
					cmd.fin    = (stat.is_put && stat.put_ok) ? FIN_OK : FIN_FAIL;
					state_d    = ST_IDLE;
				end
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (stat.found) begin
					state_d = ST_MARK;
				end else if (stat.scan_fail) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			ST_MARK: begin
				cmd.mark_rd = 1'b1;
				if (stat.mark_at_last) begin
					state_d = ST_MARK_END;
				end
			end
			ST_MARK_END: begin
				cmd.finish = 1'b1;
				cmd.fin    = stat.is_alloc ? FIN_ALLOC : FIN_OK;
				state_d    = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Hold state and the result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= cmd.finish;
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;

	`PBA_ASSERT_IMP(a_done_when_idle, clk, arst_n, done_q, state_q == ST_IDLE)
	`PBA_ASSERT_NEXT(a_mark_end_reports, clk, arst_n, state_q == ST_MARK_END, done_q)
	`PBA_ASSERT_IMP(a_scan_one_outcome, clk, arst_n, state_q == ST_SCAN, !(stat.found && stat.scan_fail))
	`PBA_ASSERT_NEXT(a_load_to_check, clk, arst_n, cmd.load, state_q == ST_CHECK)

endmodule

// File: rtl/core/page_bitmap_allocator.sv
// Allocate checks the item, scans map words up to the first fit, marks the words of the run
// and reports; free and reserve check the item, mark the words of the range and report.
// Items that fail the count or range check report straight after the check, and a scan with
// no fit reports once the last map word is scanned. One item at a time: busy falls as done
// rises and a new item is taken at the edge ending the done cycle; the map RAM reads one word a cycle.
// Reset frees all pages via per-word valid flags, sets base 0 and 4096 pages; done never stalls.
module page_bitmap_allocator import pba_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  pba_item_t         item,
	output logic              done,
	output pba_result_t       result,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic              cfg_index,
	input  logic [PAGE_W-1:0] cfg_data
);

	pba_cmd_t  cmd;
	pba_stat_t stat;

	// Configuration beats are always taken
	assign cfg_ready = 1'b1;

	pba_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.done  (done),
		.stat  (stat),
		.cmd   (cmd)
	);

	pba_datapath u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.item     (item),
		.cfg_we   (cfg_valid & cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.result   (result)
	);

endmodule

// File: tb/pba_ledger_pkg.sv
`timescale 1ns / 1ps
package pba_ledger_pkg;
	import pba_pkg::*;

	// Action code with no defined operation
	localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

	// Page map shadow and queue of answers owed by the allocator
	class frame_ledger;
		bit [MAX_PAGES-1:0] free_map;
		logic [PAGE_W-1:0]  base_page;
		logic [COUNT_W-1:0] page_total;
		pba_result_t        answers_due[$];
		int                 errors;

		function new();
			free_map   = '1;
			base_page  = BASE_RESET;
			page_total = PAGES_RESET;
			errors     = 0;
		endfunction

		function void write_reg(logic idx, logic [PAGE_W-1:0] data);
			if (idx == REG_BASE) begin
				base_page = data;
			end else begin
				page_total = data[COUNT_W-1:0];
			end
		endfunction

		// Pages past MAX_PAGES are not managed
		function int unsigned region_span();
			return (page_total > MAX_PAGES) ? MAX_PAGES : page_total;
		endfunction

		function void mark_range(int unsigned first, int unsigned count, bit freed);
			for (int i = 0; i < count; i++)
				free_map[first + i] = freed;
		endfunction

		// Work out the answer for one accepted request beat
		function void take_request(pba_item_t it);
			pba_result_t       ans;
			int unsigned       span;
			int unsigned       run;
			int unsigned       run_start;
			logic [PAGE_W-1:0] off;
			span           = region_span();
			ans.status     = 1'b1;
			ans.start_page = '0;
			case (it.action)
				ACT_ALLOC: begin
					if (it.page_count != 0 && it.page_count <= span) begin
						run       = 0;
						run_start = 0;
						// First fit from the lowest page
						for (int p = 0; p < span; p++) begin
							if (free_map[p]) begin
								run++;
								if (run == it.page_count) begin
									mark_range(run_start, it.page_count, 1'b0);
									ans.status     = 1'b0;
									ans.start_page = base_page + PAGE_W'(run_start);
									break;
								end
							end else begin
								run       = 0;
								run_start = p + 1;
							end
						end
					end
				end
				ACT_FREE, ACT_RESERVE: begin
					if (it.page_number >= base_page) begin
						off = it.page_number - base_page;
						if (off <= span && it.page_count <= span - off) begin
							mark_range(off, it.page_count, it.action == ACT_FREE);
							ans.status = 1'b0;
						end
					end
				end
				default: ;
			endcase
			answers_due.push_back(ans);
		endfunction

		// Compare one result beat with the oldest answer owed
		function void match_answer(pba_result_t got);
			pba_result_t want;
			if (answers_due.size() == 0) begin
				$display("%0t: result with none owed: status=%0b start_page=%h",
					$time, got.status, got.start_page);
				errors++;
				return;
			end
			want = answers_due.pop_front();
			if (got.status !== want.status) begin
				$display("%0t: status expected %0b actual %0b", $time, want.status, got.status);
				errors++;
			end
			if (got.start_page !== want.start_page) begin
				$display("%0t: start_page expected %h actual %h",
					$time, want.start_page, got.start_page);
				errors++;
			end
		endfunction

		function int count_due();
			return answers_due.size();
		endfunction
	endclass

endpackage

// File: tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
	import pba_pkg::*;
	import pba_ledger_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int TAIL_CYCLES = 140;
	localparam int PHASE_ITEMS = 94;
	localparam int PHASES      = 8;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              start;
	logic              busy;
	pba_item_t         item;
	logic              done;
	pba_result_t       result;
	logic              cfg_valid;
	logic              cfg_ready;
	logic              cfg_index;
	logic [PAGE_W-1:0] cfg_data;

	frame_ledger ledger = new();
	bit          quiet_stretch;
	int          stall_cycles;

	page_bitmap_allocator u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.item      (item),
		.done      (done),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Check every result beat
	always @(posedge clk) begin
		if (arst_n && done)
			ledger.match_answer(result);
	end

	// End a run that stops making progress
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
			stall_cycles = 0;
		end else begin
			stall_cycles++;
		end
		if (stall_cycles >= STALL_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	function automatic int idle_gap();
		if (quiet_stretch || $urandom_range(0, 99) >= 14)
			return 0;
		return $urandom_range(1, 6);
	endfunction

	function automatic logic [PAGE_W-1:0] rand_page();
		return PAGE_W'({$urandom, $urandom});
	endfunction

	// Drive one request beat and wait for the block to take it
	task automatic send_item(input logic [ACTION_W-1:0] act, input logic [PAGE_W-1:0] pg,
			input logic [COUNT_W-1:0] cnt);
		pba_item_t it;
		int        gap;
		it.action      = act;
		it.page_number = pg;
		it.page_count  = cnt;
		gap            = idle_gap();
		repeat (gap) begin
			@(negedge clk);
			start <= 1'b0;
		end
		@(negedge clk);
		start <= 1'b1;
		item  <= it;
		do @(posedge clk); while (busy);
		ledger.take_request(it);
	endtask

	task automatic write_reg(input logic idx, input logic [PAGE_W-1:0] data);
		repeat (idle_gap()) @(negedge clk);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		ledger.write_reg(idx, data);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Hold off requests until every owed answer is back
	task automatic drain_answers();
		@(negedge clk);
		start <= 1'b0;
		while (ledger.count_due() != 0) @(posedge clk);
	endtask

	task automatic set_region(input logic [PAGE_W-1:0] base, input logic [COUNT_W-1:0] pages);
		drain_answers();
		write_reg(REG_BASE, base);
		write_reg(REG_PAGES, PAGE_W'(pages));
	endtask

	// Mostly well-formed requests inside the region, some noise
	task automatic random_item();
		int unsigned roll;
		int unsigned span;
		int unsigned off;
		int unsigned cnt;
		span = ledger.region_span();
		roll = $urandom_range(0, 99);
		if (roll < 40) begin
			cnt = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 4096) : $urandom_range(1, 48);
			send_item(ACT_ALLOC, rand_page(), COUNT_W'(cnt));
		end else if (roll < 88) begin
			off = (span == 0) ? 0 : $urandom_range(0, span - 1);
			cnt = $urandom_range(1, 128);
			if (cnt > span - off)
				cnt = span - off;
			send_item((roll < 70) ? ACT_FREE : ACT_RESERVE, ledger.base_page + PAGE_W'(off),
				COUNT_W'(cnt));
		end else begin
			case ($urandom_range(0, 3))
				0: send_item(ACT_UNUSED, rand_page(), COUNT_W'($urandom));
				1: send_item($urandom_range(0, 1) ? ACT_FREE : ACT_RESERVE, rand_page(),
					COUNT_W'($urandom));
				2: send_item($urandom_range(0, 1) ? ACT_FREE : ACT_RESERVE,
					ledger.base_page + PAGE_W'(span), COUNT_W'($urandom_range(0, 1)));
				default: send_item(ACT_ALLOC, rand_page(), $urandom_range(0, 1) ? '0 :
					COUNT_W'(span + $urandom_range(1, 8191 - span)));
			endcase
		end
	endtask

	initial begin
		arst_n    = 1'b0;
		start     = 1'b0;
		item      = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_BASE;
		cfg_data  = '0;
		quiet_stretch = 1'b0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		// Directed: reset region of base 0 and 4096 pages
		send_item(ACT_ALLOC, '0, '0);
		send_item(ACT_ALLOC, '0, 13'd4096);
		send_item(ACT_ALLOC, '0, 13'd1);
		send_item(ACT_FREE, '0, 13'd4096);
		send_item(ACT_RESERVE, 40'd4095, 13'd1);
		send_item(ACT_ALLOC, '0, 13'd4096);
		send_item(ACT_ALLOC, '1, '1);
		send_item(ACT_FREE, 40'd4096, '0);
		send_item(ACT_FREE, 40'd4097, '0);
		send_item(ACT_RESERVE, 40'd100, 13'd28);
		send_item(ACT_ALLOC, '0, 13'd100);
		send_item(ACT_ALLOC, '0, 13'd1);
		send_item(ACT_UNUSED, '1, '1);
		send_item(ACT_FREE, '1, '1);
		send_item(ACT_FREE, '0, 13'd4096);
		send_item(ACT_RESERVE, '0, 13'h180);

		// Directed: base near the top so the run start wraps
		set_region(40'hFF_FFFF_FF00, '1);
		send_item(ACT_ALLOC, '0, 13'd1);
		send_item(ACT_FREE, '0, 13'd1);
		send_item(ACT_FREE, '1, 13'd1);
		send_item(ACT_ALLOC, '0, 13'd1);
		send_item(ACT_RESERVE, 40'hFF_FFFF_FF00, 13'd4096);

		// Directed: empty region
		set_region(40'hFF_FFFF_FF00, '0);
		send_item(ACT_ALLOC, '0, 13'd1);
		send_item(ACT_FREE, 40'hFF_FFFF_FF00, '0);
		send_item(ACT_FREE, 40'hFF_FFFF_FF00, 13'd1);

		// Directed: shrunk region leaves upper pages untouched
		set_region('0, 13'd64);
		send_item(ACT_FREE, '0, 13'd64);
		send_item(ACT_ALLOC, '0, 13'd65);
		send_item(ACT_ALLOC, '0, 13'd64);

		// Random phases over several region settings
		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: set_region('0, 13'd4096);
				1: set_region(40'hFF_FFFF_F000, '1);
				2: set_region(rand_page() >> $urandom_range(0, 30), 13'd64);
				3: set_region('1, 13'd1);
				4: set_region(rand_page() >> $urandom_range(0, 30),
					COUNT_W'($urandom_range(1, 4096)));
				5: set_region('0, '0);
				6: set_region(rand_page() >> $urandom_range(0, 30), 13'd4095);
				default: set_region('0, 13'd4096);
			endcase
			quiet_stretch = (ph == 4);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if ($urandom_range(0, 59) == 0)
					drain_answers();
				random_item();
			end
		end

		drain_answers();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (ledger.errors == 0 && ledger.count_due() == 0) begin
			$display("end of test: clean");
		end else begin
			if (ledger.count_due() != 0)
				$display("%0t: %0d answers never arrived", $time, ledger.count_due());
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/pba_pkg.sv
rtl/core/pba_ram.sv
rtl/core/pba_datapath.sv
rtl/core/pba_ctrl.sv
rtl/core/page_bitmap_allocator.sv
tb/pba_ledger_pkg.sv
tb/tb_top.sv
